### hdl/sadv_pkg.sv
// Shared types, constants and object ID tables for the sensor advert field parser.
// No dependencies.
`timescale 1ns / 1ps

package sadv_pkg;

  // Header and length checks
  localparam logic [7:0] HdrByte0    = 8'hd2;
  localparam logic [7:0] HdrByte1    = 8'hfc;
  localparam logic [7:0] HdrFlagMask = 8'he5;
  localparam logic [7:0] HdrFlagVal  = 8'h40;
  localparam int unsigned MinPacketLen = 9;

  // Object IDs of note
  localparam logic [7:0] IdBattery  = 8'h01;
  localparam logic [7:0] IdTemp     = 8'h02;
  localparam logic [7:0] IdHumidity = 8'h03;
  localparam logic [7:0] IdVoltage  = 8'h0c;
  localparam logic [7:0] IdText     = 8'h53;
  localparam logic [7:0] IdRaw      = 8'h54;

  typedef enum logic [2:0] {
    ClsNone  = 3'd0,
    ClsOne   = 3'd1,
    ClsTwo   = 3'd2,
    ClsSkip3 = 3'd3,
    ClsSkip4 = 3'd4,
    ClsVar   = 3'd5
  } obj_class_e;

  typedef enum logic [1:0] {
    KindBattery  = 2'd0,
    KindTemp     = 2'd1,
    KindHumidity = 2'd2,
    KindVoltage  = 2'd3
  } reading_kind_e;

  // Payload size class of an object ID
  function automatic obj_class_e object_class(input logic [7:0] id);
    obj_class_e cls;
    cls = ClsNone;
    if (id inside {8'h00, 8'h01, 8'h09, 8'h2e, 8'h2f, 8'h46, [8'h15:8'h1c], 8'h0f,
                   [8'h1d:8'h23], 8'h10, [8'h25:8'h2d], 8'h3a}) begin
      cls = ClsOne;
    end else if (id inside {8'h02, 8'h03, 8'h0c, 8'h12, 8'h3d, 8'h43, 8'h08, 8'h40,
                            8'h41, 8'h52, 8'h06, 8'h07, 8'h14, 8'h0d, 8'h0e, 8'h3f,
                            8'h44, 8'h45, 8'h13, 8'h4a, 8'h47, 8'h48, 8'h49, 8'h3c,
                            8'hf0}) begin
      cls = ClsTwo;
    end else if (id inside {8'h42, 8'h0a, 8'h4b, 8'h05, 8'h0b, 8'h04, 8'hf2}) begin
      cls = ClsSkip3;
    end else if (id inside {8'h3e, 8'h4d, 8'h4c, 8'h50, 8'h55, 8'h4f, 8'hf1}) begin
      cls = ClsSkip4;
    end else if (id == IdText || id == IdRaw) begin
      cls = ClsVar;
    end
    return cls;
  endfunction

  typedef struct packed {
    logic          tracked;
    reading_kind_e kind;
  } track_t;

  // Reported reading kind of an object ID, if any
  function automatic track_t tracked_kind(input logic [7:0] id);
    track_t t;
    t.tracked = 1'b1;
    t.kind    = KindBattery;
    case (id)
      IdBattery:  t.kind = KindBattery;
      IdTemp:     t.kind = KindTemp;
      IdHumidity: t.kind = KindHumidity;
      IdVoltage:  t.kind = KindVoltage;
      default:    t.tracked = 1'b0;
    endcase
    return t;
  endfunction

endpackage

### hdl/sensor_advert_field_parser.sv
// Streaming parser for sensor advert service data: header checks and object walk.
// Depends on sadv_pkg.
// An accepted input beat passes the input register, then the result register, to its
//   result beat. Throughput: one byte per cycle while the result stream is not stalled;
//   the per-byte work is one table lookup on the ID and a small phase update between those two registers.
// Bytes that give no result (mid-object bytes, bytes past the packet) only update state.
// Reset (rst_ni low, asynchronous): both stages empty, parser back in header phase,
//   position and stored length zero, so bytes before the first packet start are dropped.
`timescale 1ns / 1ps

module sensor_advert_field_parser #(
  parameter int unsigned MAX_SERVICE_BYTES = 31  // 9 .. 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [12:8] packet_length, [15:13] zero
  input  logic        s_axis_tuser,   // [0] first_byte
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] reading_value (signed)
  output logic [3:0]  m_axis_tuser,   // [0] reading_valid, [2:1] reading_kind,
                                      // [3] packet_accepted
  output logic        m_axis_tlast    // packet_done
);

  // Position and length counters are sized to the largest packet kept.
  localparam int unsigned PosW = $clog2(MAX_SERVICE_BYTES + 1);
  localparam int unsigned CmpW = (PosW > 5) ? PosW : 5;
  localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_SERVICE_BYTES);
  localparam logic [PosW-1:0] MinLen = PosW'(sadv_pkg::MinPacketLen);

  // Parse phase codes
  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhId     = 3'd1;
  localparam logic [2:0] PhVal1   = 3'd2;
  localparam logic [2:0] PhVal2Lo = 3'd3;
  localparam logic [2:0] PhVal2Hi = 3'd4;
  localparam logic [2:0] PhSkip   = 3'd5;
  localparam logic [2:0] PhLenB   = 3'd6;

  // ---------------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------------
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_first_q;
  logic [4:0]      in_len_q;

  logic            out_valid_q;
  logic            out_free;
  logic            advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;   // byte moves into the parse stage
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata[7:0];
      in_len_q   <= s_axis_tdata[12:8];
      in_first_q <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PosW-1:0]     len_q, len_d;
  logic [2:0]          phase_q, phase_d;
  logic [7:0]          skip_q, skip_d;
  sadv_pkg::track_t    obj_q, obj_d;
  logic [7:0]          low_q, low_d;
  logic                hdr_ok_q, hdr_ok_d;

  // State seen by this byte: a first byte restarts from the reset values.
  logic [CmpW-1:0]     len_ext;
  logic [PosW-1:0]     cur_pos, cur_len, pos_inc;
  logic [2:0]          cur_phase;
  logic [7:0]          cur_skip, cur_low;
  sadv_pkg::track_t    cur_obj;
  logic                cur_hdr_ok;
  logic                in_packet;
  logic                walking;
  sadv_pkg::obj_class_e id_cls;
  sadv_pkg::track_t    id_trk;

  // Result of this byte
  logic                got;
  sadv_pkg::reading_kind_e kind;
  logic [15:0]         value;
  logic                done;
  logic                accepted;

  assign len_ext = CmpW'(in_len_q);

  always_comb begin
    if (in_first_q) begin
      cur_len    = (len_ext < MaxLen) ? PosW'(len_ext) : PosW'(MaxLen);
      cur_pos    = '0;
      cur_phase  = PhHeader;
      cur_skip   = '0;
      cur_obj    = '{tracked: 1'b0, kind: sadv_pkg::KindBattery};
      cur_low    = '0;
      cur_hdr_ok = 1'b0;
    end else begin
      cur_len    = len_q;
      cur_pos    = pos_q;
      cur_phase  = phase_q;
      cur_skip   = skip_q;
      cur_obj    = obj_q;
      cur_low    = low_q;
      cur_hdr_ok = hdr_ok_q;
    end
  end

  assign in_packet = cur_pos < cur_len;
  assign pos_inc   = cur_pos + 1'b1;  // cannot wrap: cur_pos < cur_len <= max
  assign id_cls    = sadv_pkg::object_class(in_byte_q);
  assign id_trk    = sadv_pkg::tracked_kind(in_byte_q);
  assign walking   = cur_hdr_ok && (cur_len >= MinLen);

  always_comb begin
    len_d    = cur_len;
    pos_d    = cur_pos;
    phase_d  = cur_phase;
    skip_d   = cur_skip;
    obj_d    = cur_obj;
    low_d    = cur_low;
    hdr_ok_d = cur_hdr_ok;
    got      = 1'b0;
    kind     = sadv_pkg::KindBattery;
    value    = '0;

    if (in_packet) begin
      pos_d = pos_inc;
      if (cur_phase == PhHeader) begin
        if (cur_pos == '0) begin
          hdr_ok_d = (in_byte_q == sadv_pkg::HdrByte0);
        end else if (cur_pos == PosW'(1)) begin
          hdr_ok_d = cur_hdr_ok && (in_byte_q == sadv_pkg::HdrByte1);
        end else begin
          hdr_ok_d = cur_hdr_ok &&
                     ((in_byte_q & sadv_pkg::HdrFlagMask) == sadv_pkg::HdrFlagVal);
          phase_d  = PhId;
        end
      end else if (walking) begin
        case (cur_phase)
          PhId: begin
            // an ID in the final byte has no room for a payload
            if (pos_inc < cur_len) begin
              obj_d = id_trk;
              case (id_cls)
                sadv_pkg::ClsOne:   phase_d = PhVal1;
                sadv_pkg::ClsTwo:   phase_d = PhVal2Lo;
                sadv_pkg::ClsSkip3: begin
                  skip_d  = 8'd3;
                  phase_d = PhSkip;
                end
                sadv_pkg::ClsSkip4: begin
                  skip_d  = 8'd4;
                  phase_d = PhSkip;
                end
                sadv_pkg::ClsVar:   phase_d = PhLenB;
                default:            phase_d = PhId;  // unknown ID skips only itself
              endcase
            end
          end
          PhVal1: begin
            got     = cur_obj.tracked;
            kind    = cur_obj.tracked ? cur_obj.kind : sadv_pkg::KindBattery;
            value   = cur_obj.tracked ? {8'h00, in_byte_q} : 16'h0000;
            phase_d = PhId;
          end
          PhVal2Lo: begin
            low_d   = in_byte_q;
            phase_d = PhVal2Hi;
          end
          PhVal2Hi: begin
            got     = cur_obj.tracked;
            kind    = cur_obj.tracked ? cur_obj.kind : sadv_pkg::KindBattery;
            value   = cur_obj.tracked ? {in_byte_q, cur_low} : 16'h0000;
            phase_d = PhId;
          end
          PhSkip: begin
            skip_d = (cur_skip != 8'd0) ? cur_skip - 8'd1 : 8'd0;
            if (cur_skip <= 8'd1) begin
              phase_d = PhId;
            end
          end
          PhLenB: begin
            skip_d  = in_byte_q;
            phase_d = (in_byte_q != 8'd0) ? PhSkip : PhId;
          end
          default: phase_d = PhId;
        endcase
      end
    end
  end

  assign done     = in_packet && (pos_inc == cur_len);
  assign accepted = hdr_ok_d && (cur_len >= MinLen) && (cur_pos >= PosW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      phase_q  <= PhHeader;
      skip_q   <= '0;
      obj_q    <= '{tracked: 1'b0, kind: sadv_pkg::KindBattery};
      low_q    <= '0;
      hdr_ok_q <= 1'b0;
    end else if (advance) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      obj_q    <= obj_d;
      low_q    <= low_d;
      hdr_ok_q <= hdr_ok_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register; loaded only when the byte gives a reading or ends a packet
  // ---------------------------------------------------------------------------
  logic                    res_load;
  logic [15:0]             out_value_q;
  sadv_pkg::reading_kind_e out_kind_q;
  logic                    out_got_q;
  logic                    out_done_q;
  logic                    out_acc_q;

  assign res_load = advance && (got || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_value_q <= value;
      out_kind_q  <= kind;
      out_got_q   <= got;
      out_done_q  <= done;
      out_acc_q   <= accepted;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = {out_acc_q, out_kind_q, out_got_q};
  assign m_axis_tlast  = out_done_q;

endmodule
